### hdl/bcbs_pkg.sv
// ----------------------------------------------------------------------------
// bcbs_pkg
// Types and codes shared by the bucket collision batch scheduler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bcbs_pkg;

  localparam int IN_BKT_W   = 12;
  localparam int IN_TAG_W   = 16;
  localparam int OUT_BKT_W  = 12;
  localparam int OUT_TAG_W  = 16;
  localparam int OUT_SLOT_W = 8;
  localparam int OUT_SIZE_W = 9;
  localparam int BLIM_W     = 9;
  localparam int DLIM_W     = 5;
  localparam int CFG_DATA_W = 9;

  // request codes
  localparam logic ACT_ADD    = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  // result codes
  localparam logic KIND_DISPATCH = 1'b0;
  localparam logic KIND_CLOSE    = 1'b1;

  // register indexes
  localparam logic CFG_BATCH_LIMIT = 1'b0;
  localparam logic CFG_DEFER_LIMIT = 1'b1;

  typedef struct packed {
    logic                act;
    logic [IN_BKT_W-1:0] bkt;
    logic [IN_TAG_W-1:0] tag;
  } item_t;

  typedef struct packed {
    logic                  kind;
    logic [OUT_BKT_W-1:0]  bkt;
    logic [OUT_TAG_W-1:0]  tag;
    logic [OUT_SLOT_W-1:0] slot;
    logic [OUT_SIZE_W-1:0] size;
    logic                  last;
  } res_t;

  typedef struct packed {
    logic                  we;
    logic                  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_t;

endpackage

`default_nettype wire

### hdl/bcbs_front.sv
// ----------------------------------------------------------------------------
// bcbs_front
// Input side: takes request words into a two-entry queue for the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module bcbs_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  bcbs_pkg::item_t     in_item_i,
  output logic                q_valid_o,
  output bcbs_pkg::item_t     q_item_o,
  input  wire                 q_pop_i
);
  import bcbs_pkg::*;

  item_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rd_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/bcbs_engine.sv
// ----------------------------------------------------------------------------
// bcbs_engine
// Back end: collision map, link store lists, batch close and deferred rescan.
// ----------------------------------------------------------------------------
`default_nettype none

module bcbs_engine #(
  parameter int BUCKET_BITS = 12,
  parameter int MAX_BATCH   = 256,
  parameter int MAX_DEFER   = 16,
  parameter int TAG_BITS    = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  bcbs_pkg::cfg_t      cfg_i,
  input  wire                 q_valid_i,
  input  bcbs_pkg::item_t     q_item_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output bcbs_pkg::res_t      out_o
);
  import bcbs_pkg::*;

  localparam int NBUCKETS = 1 << BUCKET_BITS;
  localparam int NSLOTS   = 2 * MAX_DEFER;
  localparam int SW       = $clog2(NSLOTS);
  localparam int BW       = $clog2(MAX_BATCH);
  localparam int CW       = $clog2(MAX_BATCH + 1);
  localparam int DW       = $clog2(MAX_DEFER + 1);
  localparam int IW       = (BUCKET_BITS > SW) ? BUCKET_BITS : SW;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_ADD, ST_CLOSE, ST_CLR, ST_SCAN, ST_SMAP, ST_SDEC, ST_FLUSH
  } state_e;

  state_e state_q;

  // memories
  logic                   map_mem  [NBUCKETS];
  logic [BUCKET_BITS-1:0] slot_mem [MAX_BATCH];
  logic [SW-1:0]          nxt_mem  [NSLOTS];
  logic [BUCKET_BITS-1:0] bkt_mem  [NSLOTS];
  logic [TAG_BITS-1:0]    tag_mem  [NSLOTS];

  logic                   map_rd_q;
  logic [BUCKET_BITS-1:0] slot_rd_q;
  logic [SW-1:0]          lnk_nxt_q;
  logic [BUCKET_BITS-1:0] lnk_bkt_q;
  logic [TAG_BITS-1:0]    lnk_tag_q;

  logic                   map_we, map_wd, map_re;
  logic [BUCKET_BITS-1:0] map_wa, map_ra;
  logic                   slot_we, slot_re;
  logic [BW-1:0]          slot_wa, slot_ra;
  logic [BUCKET_BITS-1:0] slot_wd;
  logic                   nxt_we, dat_we, lnk_re;
  logic [SW-1:0]          nxt_wa, nxt_wd, dat_wa, lnk_ra;
  logic [BUCKET_BITS-1:0] bkt_wd;
  logic [TAG_BITS-1:0]    tag_wd;

  // control state
  logic [IW-1:0]          sweep_q;
  logic [SW-1:0]          free_hd_q, free_tl_q, rdy_hd_q, rdy_tl_q, def_hd_q, def_tl_q;
  logic                   free_v_q, rdy_v_q, def_v_q;
  logic [CW-1:0]          bcnt_q, clr_n_q, clr_i_q;
  logic [DW-1:0]          dcnt_q, n_q, i_q;
  logic [SW-1:0]          cur_q;
  logic                   had_q, clr_rd_v_q, fin_q;
  logic [BLIM_W-1:0]      blim_q;
  logic [DLIM_W-1:0]      dlim_q;
  logic [BUCKET_BITS-1:0] it_bkt_q;
  logic [TAG_BITS-1:0]    it_tag_q;

  // pending result, held back until it is known whether it ends the word's results
  logic                   pend_v_q, pend_kind_q;
  logic [BUCKET_BITS-1:0] pend_bkt_q;
  logic [TAG_BITS-1:0]    pend_tag_q;
  logic [CW-1:0]          pend_slot_q, pend_size_q;
  logic                   out_v_q;
  res_t                   out_q;

  logic                   em_en, em_kind;
  logic [BUCKET_BITS-1:0] em_bkt;
  logic [TAG_BITS-1:0]    em_tag;
  logic [CW-1:0]          em_slot, em_size;
  logic                   flush_en, out_load;

  logic [31:0] bc32, dc32, b32, d32, eff_b, eff_d, add_b32, add_d32, sw32;
  logic [31:0] pb32, pt32, ps32, pz32;
  logic        out_free, emit_ok, add_new, add_close, scan_disp, scan_more, clr_more;

  assign bc32  = 32'(bcnt_q);
  assign dc32  = 32'(dcnt_q);
  assign b32   = 32'(blim_q);
  assign d32   = 32'(dlim_q);
  assign sw32  = 32'(sweep_q);
  assign eff_b = (b32 == 32'd0) ? 32'd1 : ((b32 > 32'(MAX_BATCH)) ? 32'(MAX_BATCH) : b32);
  assign eff_d = (d32 == 32'd0) ? 32'd1 : ((d32 > 32'(MAX_DEFER)) ? 32'(MAX_DEFER) : d32);

  assign out_free  = !out_v_q || out_ready_i;
  assign emit_ok   = !pend_v_q || out_free;
  assign add_new   = !map_rd_q;
  assign add_b32   = add_new ? bc32 + 32'd1 : bc32;
  assign add_d32   = (!add_new && free_v_q) ? dc32 + 32'd1 : dc32;
  assign add_close = (add_d32 >= eff_d) || (add_b32 >= eff_b);
  assign scan_disp = (bc32 < eff_b) && !map_rd_q;
  assign scan_more = had_q && (i_q < n_q);
  assign clr_more  = clr_i_q < clr_n_q;

  assign pb32 = 32'(pend_bkt_q);
  assign pt32 = 32'(pend_tag_q);
  assign ps32 = 32'(pend_slot_q);
  assign pz32 = 32'(pend_size_q);

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;
  assign q_pop_o     = (state_q == ST_IDLE) && q_valid_i;

  always_comb begin
    map_we = 1'b0; map_wa = '0; map_wd = 1'b0; map_re = 1'b0; map_ra = '0;
    slot_we = 1'b0; slot_wa = '0; slot_wd = '0; slot_re = 1'b0; slot_ra = '0;
    nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0;
    dat_we = 1'b0; dat_wa = '0; bkt_wd = '0; tag_wd = '0;
    lnk_re = 1'b0; lnk_ra = '0;
    em_en = 1'b0; em_kind = KIND_DISPATCH; em_bkt = '0; em_tag = '0;
    em_slot = '0; em_size = '0;
    flush_en = 1'b0;
    case (state_q)
      ST_INIT: begin
        // power-up sweep: clear the map, chain the link store as one free list
        map_we = sw32 < 32'(NBUCKETS);
        map_wa = sweep_q[BUCKET_BITS-1:0];
        nxt_we = sw32 < 32'(NSLOTS);
        nxt_wa = sweep_q[SW-1:0];
        nxt_wd = (sw32 == 32'(NSLOTS - 1)) ? '0 : SW'(sw32 + 32'd1);
      end
      ST_IDLE: begin
        map_re = q_valid_i;
        map_ra = BUCKET_BITS'(q_item_i.bkt);
        lnk_re = q_valid_i;
        lnk_ra = free_hd_q;
      end
      ST_ADD: begin
        if (add_new) begin
          if (emit_ok) begin
            map_we  = 1'b1;
            map_wa  = it_bkt_q;
            map_wd  = 1'b1;
            slot_we = 1'b1;
            slot_wa = bcnt_q[BW-1:0];
            slot_wd = it_bkt_q;
            em_en   = 1'b1;
            em_bkt  = it_bkt_q;
            em_tag  = it_tag_q;
            em_slot = bcnt_q;
          end
        end else if (free_v_q) begin
          dat_we = 1'b1;
          dat_wa = free_hd_q;
          bkt_wd = it_bkt_q;
          tag_wd = it_tag_q;
          nxt_we = def_v_q;
          nxt_wa = def_tl_q;
          nxt_wd = free_hd_q;
        end
      end
      ST_CLOSE: begin
        if (emit_ok) begin
          em_en   = 1'b1;
          em_kind = KIND_CLOSE;
          em_size = bcnt_q;
          nxt_we  = rdy_v_q && free_v_q;
          nxt_wa  = free_tl_q;
          nxt_wd  = rdy_hd_q;
        end
      end
      ST_CLR: begin
        // unmark every bucket dispatched in the closed batch
        slot_re = clr_more;
        slot_ra = clr_i_q[BW-1:0];
        map_we  = clr_rd_v_q;
        map_wa  = slot_rd_q;
      end
      ST_SCAN: begin
        lnk_re = scan_more;
        lnk_ra = cur_q;
      end
      ST_SMAP: begin
        map_re = 1'b1;
        map_ra = lnk_bkt_q;
      end
      ST_SDEC: begin
        if (scan_disp) begin
          if (emit_ok) begin
            map_we  = 1'b1;
            map_wa  = lnk_bkt_q;
            map_wd  = 1'b1;
            slot_we = 1'b1;
            slot_wa = bcnt_q[BW-1:0];
            slot_wd = lnk_bkt_q;
            em_en   = 1'b1;
            em_bkt  = lnk_bkt_q;
            em_tag  = lnk_tag_q;
            em_slot = bcnt_q;
            nxt_we  = rdy_v_q;
            nxt_wa  = rdy_tl_q;
            nxt_wd  = cur_q;
          end
        end else begin
          nxt_we = def_v_q;
          nxt_wa = def_tl_q;
          nxt_wd = cur_q;
        end
      end
      ST_FLUSH: begin
        flush_en = pend_v_q && out_free;
      end
      default: ;
    endcase
  end

  assign out_load = (em_en && pend_v_q) || flush_en;

  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    if (map_re) map_rd_q <= map_mem[map_ra];
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    if (slot_re) slot_rd_q <= slot_mem[slot_ra];
  end

  always_ff @(posedge clk_i) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    if (dat_we) begin
      bkt_mem[dat_wa] <= bkt_wd;
      tag_mem[dat_wa] <= tag_wd;
    end
    if (lnk_re) begin
      lnk_nxt_q <= nxt_mem[lnk_ra];
      lnk_bkt_q <= bkt_mem[lnk_ra];
      lnk_tag_q <= tag_mem[lnk_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      sweep_q    <= '0;
      free_hd_q  <= '0;
      free_tl_q  <= SW'(NSLOTS - 1);
      free_v_q   <= 1'b1;
      rdy_hd_q   <= '0;
      rdy_tl_q   <= '0;
      rdy_v_q    <= 1'b0;
      def_hd_q   <= '0;
      def_tl_q   <= '0;
      def_v_q    <= 1'b0;
      bcnt_q     <= '0;
      dcnt_q     <= '0;
      clr_n_q    <= '0;
      clr_i_q    <= '0;
      clr_rd_v_q <= 1'b0;
      n_q        <= '0;
      i_q        <= '0;
      cur_q      <= '0;
      had_q      <= 1'b0;
      fin_q      <= 1'b0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      blim_q     <= BLIM_W'(256);
      dlim_q     <= DLIM_W'(16);
    end else begin
      if (cfg_i.we) begin
        case (cfg_i.idx)
          CFG_BATCH_LIMIT: blim_q <= cfg_i.data[BLIM_W-1:0];
          CFG_DEFER_LIMIT: dlim_q <= cfg_i.data[DLIM_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_v_q    <= 1'b1;
        out_q.kind <= pend_kind_q;
        out_q.bkt  <= pb32[OUT_BKT_W-1:0];
        out_q.tag  <= pt32[OUT_TAG_W-1:0];
        out_q.slot <= ps32[OUT_SLOT_W-1:0];
        out_q.size <= pz32[OUT_SIZE_W-1:0];
        out_q.last <= flush_en;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end

      if (em_en) begin
        pend_v_q    <= 1'b1;
        pend_kind_q <= em_kind;
        pend_bkt_q  <= em_bkt;
        pend_tag_q  <= em_tag;
        pend_slot_q <= em_slot;
        pend_size_q <= em_size;
      end else if (flush_en) begin
        pend_v_q <= 1'b0;
      end

      case (state_q)
        ST_INIT: begin
          sweep_q <= sweep_q + IW'(1);
          if (&sweep_q) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (q_valid_i) begin
            it_bkt_q <= BUCKET_BITS'(q_item_i.bkt);
            it_tag_q <= TAG_BITS'(q_item_i.tag);
            fin_q    <= q_item_i.act;
            state_q  <= (q_item_i.act == ACT_FINISH) ? ST_CLOSE : ST_ADD;
          end
        end
        ST_ADD: begin
          if (add_new) begin
            if (emit_ok) begin
              bcnt_q  <= bcnt_q + CW'(1);
              state_q <= add_close ? ST_CLOSE : ST_FLUSH;
            end
          end else begin
            if (free_v_q) begin
              if (free_hd_q == free_tl_q) free_v_q <= 1'b0;
              else free_hd_q <= lnk_nxt_q;
              if (def_v_q) begin
                def_tl_q <= free_hd_q;
              end else begin
                def_hd_q <= free_hd_q;
                def_tl_q <= free_hd_q;
                def_v_q  <= 1'b1;
              end
              dcnt_q <= dcnt_q + DW'(1);
            end
            state_q <= add_close ? ST_CLOSE : ST_FLUSH;
          end
        end
        ST_CLOSE: begin
          if (emit_ok) begin
            // ready list goes back onto the free list
            if (rdy_v_q) begin
              if (free_v_q) begin
                free_tl_q <= rdy_tl_q;
              end else begin
                free_hd_q <= rdy_hd_q;
                free_tl_q <= rdy_tl_q;
                free_v_q  <= 1'b1;
              end
              rdy_v_q <= 1'b0;
            end
            clr_n_q    <= bcnt_q;
            clr_i_q    <= '0;
            clr_rd_v_q <= 1'b0;
            bcnt_q     <= '0;
            n_q        <= dcnt_q;
            i_q        <= '0;
            cur_q      <= def_hd_q;
            had_q      <= def_v_q;
            def_v_q    <= 1'b0;
            dcnt_q     <= '0;
            state_q    <= ST_CLR;
          end
        end
        ST_CLR: begin
          clr_rd_v_q <= clr_more;
          if (clr_more) clr_i_q <= clr_i_q + CW'(1);
          if (!clr_more && !clr_rd_v_q) state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (scan_more) state_q <= ST_SMAP;
          else if (fin_q && (rdy_v_q || def_v_q)) state_q <= ST_CLOSE;
          else state_q <= ST_FLUSH;
        end
        ST_SMAP: begin
          state_q <= ST_SDEC;
        end
        ST_SDEC: begin
          if (scan_disp) begin
            if (emit_ok) begin
              bcnt_q <= bcnt_q + CW'(1);
              if (rdy_v_q) begin
                rdy_tl_q <= cur_q;
              end else begin
                rdy_hd_q <= cur_q;
                rdy_tl_q <= cur_q;
                rdy_v_q  <= 1'b1;
              end
              cur_q   <= lnk_nxt_q;
              i_q     <= i_q + DW'(1);
              state_q <= ST_SCAN;
            end
          end else begin
            dcnt_q <= dcnt_q + DW'(1);
            if (def_v_q) begin
              def_tl_q <= cur_q;
            end else begin
              def_hd_q <= cur_q;
              def_tl_q <= cur_q;
              def_v_q  <= 1'b1;
            end
            cur_q   <= lnk_nxt_q;
            i_q     <= i_q + DW'(1);
            state_q <= ST_SCAN;
          end
        end
        ST_FLUSH: begin
          if (!pend_v_q || out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // deferred count tracks the deferred list
  a_defer_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !def_v_q |-> (dcnt_q == '0))
    else $error("deferred count nonzero with empty deferred list");

  a_defer_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dc32 <= 32'(MAX_DEFER))
    else $error("deferred count above limit");

  a_batch_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bc32 <= 32'(MAX_BATCH))
    else $error("batch count above limit");

  a_idle_flushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_v_q)
    else $error("result left pending at idle");

endmodule

`default_nettype wire

### hdl/bucket_collision_batch_scheduler_core.sv
// ----------------------------------------------------------------------------
// bucket_collision_batch_scheduler_core
// Batches bucket add requests so no bucket appears twice in one batch.
// ----------------------------------------------------------------------------
// Requests arrive on s_axis: tuser is the action (add or finish), tdata holds
// bucket and point tag. Results leave on m_axis: tuser is the kind (dispatch
// or batch close), tlast marks the final result caused by a request.
// A two-entry request queue sits in front of the engine; results pass
// through a one-word hold stage and an output register, so a stalled
// receiver only stops the engine when both are full.
// An add that closes no batch passes the engine states idle, add and flush;
// its dispatch waits in the hold stage until flush moves it to m_axis.
// A batch close runs the close and clear states (map clear walks the batch's
// slot table), then rescans each deferred entry from the link store through
// the scan, map-read and decide states. A finish runs such rounds until the
// ready and deferred lists are both empty. After reset the engine sweeps the
// collision map and link store; requests queue but are not processed until
// the sweep ends. Config writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module bucket_collision_batch_scheduler_core #(
  parameter int BUCKET_BITS = 12,
  parameter int MAX_BATCH   = 256,
  parameter int MAX_DEFER   = 16,
  parameter int TAG_BITS    = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire         cfg_idx_i,
  input  wire  [8:0]  cfg_wdata_i,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // bucket[11:0], point_tag[27:12], zero pad
  input  wire         s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [47:0] m_axis_tdata,   // out_bucket[11:0], out_point_tag[27:12],
                                      // batch_slot[35:28], batch_size[44:36], pad
  output logic        m_axis_tuser,   // kind
  output logic        m_axis_tlast
);
  import bcbs_pkg::*;

  item_t in_item, q_item;
  cfg_t  cfg;
  res_t  res;
  logic  q_valid, q_pop;

  assign in_item.act = s_axis_tuser;
  assign in_item.bkt = s_axis_tdata[11:0];
  assign in_item.tag = s_axis_tdata[27:12];

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_wdata_i;

  bcbs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  bcbs_engine #(
    .BUCKET_BITS (BUCKET_BITS),
    .MAX_BATCH   (MAX_BATCH),
    .MAX_DEFER   (MAX_DEFER),
    .TAG_BITS    (TAG_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {3'b000, res.size, res.slot, res.tag, res.bkt};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire
